### hdl/tpsg_pkg.sv
// Shared constants, types and the sine table builder for the three-phase sine generator.
// Depends on nothing; included by wildcard import in three_phase_sine_generator.
`timescale 1ns / 1ps

package tpsg_pkg;

  localparam int unsigned UPDATE_RATE     = 20000;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int unsigned ADDR_W          = SINE_TABLE_BITS + 1;

  localparam int unsigned FREQ_W  = 17;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned NUM_PHASES = 3;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 72;

  // Increment is floor(freq * 2^32 / INC_DIV); it is formed as
  // freq * RECIP >> (RECIP_SHIFT - 32).
  // The shift is large enough that the reciprocal error never reaches the next integer.
  localparam int unsigned INC_DIV     = 256 * UPDATE_RATE;
  localparam int unsigned RECIP_SHIFT = 77;
  localparam logic [79:0] RECIP_FULL  =
      ((80'd1 << RECIP_SHIFT) + 80'(INC_DIV) - 80'd1) / 80'(INC_DIV);
  localparam logic [63:0] RECIP       = RECIP_FULL[63:0];
  localparam int unsigned PROD_W      = FREQ_W + 32;
  localparam int unsigned INC_SUM_W   = PROD_W + 1;
  // The recombined sum already drops the lowest 32 product bits.
  localparam int unsigned INC_LSB     = RECIP_SHIFT - 64;

  localparam logic [PHASE_W-1:0] PHASE_OFFSET [0:NUM_PHASES-1] =
      '{32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAB};

  localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
  localparam int unsigned TAYLOR_TERMS = 12;

  typedef logic [OUT_W-1:0] sine_rom_t [0:TAB_N];

  // (a * b) >> 62, where the result fits 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Entry k is round(32767 * sin(pi/2 * k / TAB_N)) from a Taylor series in Q62.
  function automatic logic [OUT_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] r;
    x    = (HALF_PI_Q62 >> SINE_TABLE_BITS) * 64'(k);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = sum >> 30;
    r = (v * 64'd32767 + 64'h8000_0000) >> 32;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[OUT_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k <= TAB_N; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### hdl/three_phase_sine_generator.sv
// Three-phase sine generator: phase accumulator, quarter-wave sine ROM and amplitude scaling.
// Depends on tpsg_pkg for constants, the reciprocal of the increment divisor and the ROM.
//
//  port group   dir   word contents (lowest bit first)
//  s_axis_*     in    tdata: frequency[16:0], amplitude[31:17]; tuser: tick_valid[0]
//  m_axis_*     out   tdata: phase_a, phase_b, phase_c, zero_crossed, applied_frequency, pad
//
// One word is taken every cycle while s_axis_tready is high. Five register stages (increment
// products, accumulator, ROM read, amplitude product, output register) lie between an input
// word and its result. A word with tick_valid low is taken and dropped without a result.
// Each stage holds while the one after it is full and stalled, so bubbles close up and
// input is still taken while a result waits. rst clears the stage flags, the phase
// accumulator, the crossing flag and the latched frequency.
`timescale 1ns / 1ps

module three_phase_sine_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tpsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // frequency, amplitude
  input  logic [0:0]                      s_axis_tuser,  // tick_valid
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // phase_a_out, phase_b_out, phase_c_out, zero_crossed, applied_frequency, zero pad
  output logic [tpsg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tpsg_pkg::*;

  // Stage enables: a stage loads when it is empty or the next stage loads.
  logic en_out;
  logic en4;
  logic en3;
  logic en2;
  logic en1;

  // Stage 1: reciprocal products of the frequency.
  logic              s1_valid;
  logic [FREQ_W-1:0] s1_freq;
  logic [AMP_W-1:0]  s1_amp;
  logic [PROD_W-1:0] s1_prod_lo;
  logic [PROD_W-1:0] s1_prod_hi;

  // Stage 2: updated phase.
  logic               s2_valid;
  logic [FREQ_W-1:0]  s2_freq;
  logic [AMP_W-1:0]   s2_amp;
  logic [PHASE_W-1:0] s2_phase;

  // Stage 3: sine magnitudes from the ROM.
  logic              s3_valid;
  logic [FREQ_W-1:0] s3_freq;
  logic [AMP_W-1:0]  s3_amp;
  logic [OUT_W-1:0]  s3_mag [0:NUM_PHASES-1];
  logic              s3_neg [0:NUM_PHASES-1];

  // Stage 4: amplitude products.
  logic                  s4_valid;
  logic [FREQ_W-1:0]     s4_freq;
  logic [2*AMP_W-1:0]    s4_prod [0:NUM_PHASES-1];
  logic                  s4_neg  [0:NUM_PHASES-1];

  // Block state.
  logic [PHASE_W-1:0] phase_accum;
  logic               last_a_negative;
  logic [FREQ_W-1:0]  latched_frequency;

  // Output register.
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_phase [0:NUM_PHASES-1];
  logic                    out_crossed;
  logic [FREQ_W-1:0]       out_freq;

  logic [INC_SUM_W-1:0]    inc_sum;
  logic [PHASE_W-1:0]      phase_accum_next;
  logic [PHASE_W-1:0]      lane_phase [0:NUM_PHASES-1];
  logic [ADDR_W-1:0]       rom_addr   [0:NUM_PHASES-1];
  logic [2*AMP_W:0]        rounded    [0:NUM_PHASES-1];
  logic [OUT_W-1:0]        scaled_mag [0:NUM_PHASES-1];
  logic signed [OUT_W-1:0] phase_val  [0:NUM_PHASES-1];
  logic                    a_negative;
  logic                    crossed;
  logic [FREQ_W-1:0]       latched_frequency_next;

  assign en_out        = !out_valid || m_axis_tready;
  assign en4           = !s4_valid || en_out;
  assign en3           = !s3_valid || en4;
  assign en2           = !s2_valid || en3;
  assign en1           = !s1_valid || en2;
  // No word is taken while reset holds the stage flags clear.
  assign s_axis_tready = en1 && !rst;

  // The reciprocal product is split in two halves and recombined in the next stage.
  assign inc_sum          = INC_SUM_W'(s1_prod_hi) + INC_SUM_W'(s1_prod_lo[PROD_W-1:32]);
  assign phase_accum_next = phase_accum + inc_sum[INC_LSB +: PHASE_W];

  // Quadrant from the top two bits; odd quadrants read the table mirrored.
  always_comb begin
    for (int j = 0; j < NUM_PHASES; j++) begin
      lane_phase[j] = s2_phase + PHASE_OFFSET[j];
      if (lane_phase[j][PHASE_W-2]) begin
        rom_addr[j] = ADDR_W'(TAB_N) -
                      ADDR_W'(lane_phase[j][PHASE_W-3 -: SINE_TABLE_BITS]);
      end else begin
        rom_addr[j] = ADDR_W'(lane_phase[j][PHASE_W-3 -: SINE_TABLE_BITS]);
      end
    end
  end

  // Negative lanes round towards minus infinity, so the magnitude rounds up.
  always_comb begin
    for (int j = 0; j < NUM_PHASES; j++) begin
      rounded[j] = (2 * AMP_W + 1)'(s4_prod[j]) + (2 * AMP_W + 1)'(32767);
      if (s4_neg[j]) begin
        scaled_mag[j] = rounded[j][2*AMP_W -: OUT_W];
        phase_val[j]  = -$signed(scaled_mag[j]);
      end else begin
        scaled_mag[j] = OUT_W'(s4_prod[j][2*AMP_W-1:15]);
        phase_val[j]  = $signed(scaled_mag[j]);
      end
    end
  end

  assign a_negative             = phase_val[0][OUT_W-1];
  assign crossed                = last_a_negative && !a_negative;
  assign latched_frequency_next = crossed ? s4_freq : latched_frequency;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      s3_valid          <= 1'b0;
      s4_valid          <= 1'b0;
      out_valid         <= 1'b0;
      phase_accum       <= '0;
      last_a_negative   <= 1'b0;
      latched_frequency <= '0;
    end else begin
      if (en1) begin
        s1_valid <= s_axis_tvalid && s_axis_tuser[0];
      end
      if (en2) begin
        s2_valid <= s1_valid;
        if (s1_valid) begin
          phase_accum <= phase_accum_next;
        end
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en4) begin
        s4_valid <= s3_valid;
      end
      if (en_out) begin
        out_valid <= s4_valid;
        if (s4_valid) begin
          last_a_negative   <= a_negative;
          latched_frequency <= latched_frequency_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_freq    <= s_axis_tdata[FREQ_W-1:0];
      s1_amp     <= s_axis_tdata[FREQ_W +: AMP_W];
      s1_prod_lo <= PROD_W'(s_axis_tdata[FREQ_W-1:0]) * PROD_W'(RECIP[31:0]);
      s1_prod_hi <= PROD_W'(s_axis_tdata[FREQ_W-1:0]) * PROD_W'(RECIP[63:32]);
    end
    if (en2) begin
      s2_freq  <= s1_freq;
      s2_amp   <= s1_amp;
      s2_phase <= phase_accum_next;
    end
    if (en3) begin
      s3_freq <= s2_freq;
      s3_amp  <= s2_amp;
      for (int j = 0; j < NUM_PHASES; j++) begin
        s3_mag[j] <= SINE_ROM[rom_addr[j]];
        s3_neg[j] <= lane_phase[j][PHASE_W-1];
      end
    end
    if (en4) begin
      s4_freq <= s3_freq;
      for (int j = 0; j < NUM_PHASES; j++) begin
        s4_prod[j] <= (2 * AMP_W)'(s3_amp) * (2 * AMP_W)'(s3_mag[j][AMP_W-1:0]);
        s4_neg[j]  <= s3_neg[j];
      end
    end
    if (en_out) begin
      for (int j = 0; j < NUM_PHASES; j++) begin
        out_phase[j] <= phase_val[j];
      end
      out_crossed <= crossed;
      out_freq    <= latched_frequency_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {
    (OUT_DATA_W - 3 * OUT_W - 1 - FREQ_W)'(0),
    out_freq,
    out_crossed,
    out_phase[2],
    out_phase[1],
    out_phase[0]
  };

  // A reported crossing always comes with a non-negative phase A.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_crossed) |-> !out_phase[0][OUT_W-1])
    else $error("zero crossing reported with negative phase A");

  // The accumulator moves only when a tick enters the accumulator stage.
  assert property (@(posedge clk) disable iff (rst)
    !(en2 && s1_valid) |=> $stable(phase_accum))
    else $error("phase accumulator moved without a tick");

  // The latched frequency changes only when a word with a zero crossing is loaded into the output register.
  assert property (@(posedge clk) disable iff (rst)
    !$stable(latched_frequency) |-> ($past(rst) || $past(en_out && s4_valid && crossed)))
    else $error("latched frequency changed outside a zero crossing");

  // Scaled values never reach the most negative code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_phase[0] != 16'sh8000 && out_phase[1] != 16'sh8000 &&
                   out_phase[2] != 16'sh8000))
    else $error("phase output out of range");

endmodule

### dv/tb_three_phase_sine_generator.sv
// Self-checking bench for the three-phase sine generator: a stimulus table, then random
// tick runs, each result compared with an in-bench model of the accumulator and sine table.
// Depends on tpsg_pkg and three_phase_sine_generator from the hdl folder.
`timescale 1ns / 1ps

module tb_three_phase_sine_generator;
  import tpsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HALF_TICKS    = 760;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AFTER    = 500;

  localparam int unsigned ROM_BITS = 10;
  localparam int unsigned ROM_TOP  = 1 << ROM_BITS;
  localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] TICK_DIVISOR     = 64'd5120000;
  localparam logic [31:0] OFFSET_B = 32'h5555_5555;
  localparam logic [31:0] OFFSET_C = 32'hAAAA_AAAB;
  localparam logic [16:0] FREQ_MAX = 17'h1FFFF;
  localparam logic [14:0] AMP_MAX  = 15'h7FFF;

  // Field order follows the output word: phase_a sits in the lowest bits.
  typedef struct packed {
    logic [16:0]        applied_freq;
    logic               crossed;
    logic signed [15:0] phase_c;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_a;
  } phase_word_t;

  typedef struct {
    logic        tick;
    logic [16:0] freq;
    logic [14:0] amp;
    logic        typed;
    phase_word_t want;
  } plan_row_t;

  localparam phase_word_t SILENT = '0;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;  // frequency, amplitude
  logic [0:0]            s_axis_tuser;  // tick_valid
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // phase_a_out, phase_b_out, phase_c_out, zero_crossed, applied_frequency, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  three_phase_sine_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [15:0]  sine_q15 [0:ROM_TOP];
  logic [31:0]  accum = '0;
  logic         a_was_negative = 1'b0;
  logic [16:0]  held_freq = '0;
  phase_word_t  phase_words_due [$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  bit           rx_holding = 1'b0;

  plan_row_t plan [20] = '{
    '{1'b1, 17'd0,     15'd0,     1'b1, SILENT},  // straight out of reset
    '{1'b1, FREQ_MAX,  15'd0,     1'b1, SILENT},  // zero amplitude gives silence
    '{1'b0, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},  // no tick
    '{1'b1, 17'd0,     AMP_MAX,   1'b0, SILENT},
    '{1'b1, 17'd1,     15'd1,     1'b0, SILENT},
    '{1'b1, 17'h15555, 15'h2AAA,  1'b0, SILENT},
    '{1'b1, 17'h0AAAA, 15'h5555,  1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT},
    '{1'b0, 17'd0,     15'd0,     1'b0, SILENT},
    '{1'b1, FREQ_MAX,  15'd0,     1'b0, SILENT},
    '{1'b1, FREQ_MAX,  15'd1,     1'b0, SILENT},
    '{1'b1, 17'h10000, 15'h4000,  1'b0, SILENT},
    '{1'b1, FREQ_MAX,  AMP_MAX,   1'b0, SILENT}
  };

  function automatic logic [63:0] q62_product(logic [63:0] x, logic [63:0] y);
    logic [127:0] wide;
    wide = {64'd0, x} * {64'd0, y};
    return wide[125:62];
  endfunction

  // Quarter-wave entry k, from an odd Taylor series evaluated in Q62.
  function automatic logic [15:0] quarter_sine(int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] rounded;
    ang    = (QUARTER_TURN_Q62 >> ROM_BITS) * 64'(k);
    ang_sq = q62_product(ang, ang);
    term   = ang;
    total  = ang;
    for (int n = 1; n <= 12; n++) begin
      term  = q62_product(term, ang_sq) / 64'((2 * n) * (2 * n + 1));
      total = (n % 2 == 1) ? total - term : total + term;
    end
    rounded = ((total >> 30) * 64'd32767 + 64'h8000_0000) >> 32;
    return (rounded > 64'd32767) ? 16'd32767 : rounded[15:0];
  endfunction

  // The top two bits pick the quadrant; odd quadrants run the table backwards and the
  // second half-turn is negated before the floor shift.
  function automatic logic signed [15:0] scaled_sine(logic [14:0] a, logic [31:0] p);
    logic [10:0] idx;
    int          prod;
    idx = {1'b0, p[29 -: ROM_BITS]};
    if (p[30]) begin
      idx = 11'(ROM_TOP) - idx;
    end
    prod = int'(a) * int'(sine_q15[idx]);
    if (p[31]) begin
      prod = -prod;
    end
    return 16'(prod >>> 15);
  endfunction

  function automatic phase_word_t advance_generator(logic [16:0] f, logic [14:0] a);
    phase_word_t w;
    logic [63:0] step;
    step  = {15'd0, f, 32'd0} / TICK_DIVISOR;
    accum = accum + step[31:0];
    w.phase_a = scaled_sine(a, accum);
    w.phase_b = scaled_sine(a, accum + OFFSET_B);
    w.phase_c = scaled_sine(a, accum + OFFSET_C);
    w.crossed = a_was_negative && !w.phase_a[15];
    a_was_negative = w.phase_a[15];
    if (w.crossed) begin
      held_freq = f;
    end
    w.applied_freq = held_freq;
    return w;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic offer(logic tick, logic [16:0] f, logic [14:0] a,
                       logic typed = 1'b0, phase_word_t want = '0);
    int unsigned gap;
    phase_word_t due;
    gap = (tx_calm || rx_holding) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, f};
    s_axis_tuser  <= tick;
    do @(posedge clk); while (!s_axis_tready);
    if (tick) begin
      due = advance_generator(f, a);
      phase_words_due.push_back(typed ? want : due);
    end
  endtask

  // Waits on the clock before checking the queue, so valid is never dropped and raised in one step.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (phase_words_due.size() != 0);
  endtask

  // Runs of steady frequency and amplitude so that phase A keeps crossing zero, with
  // occasional drifts, one-off frequencies and dropped ticks mixed in.
  task automatic random_ticks(int unsigned count);
    int unsigned done_ticks;
    int unsigned run_len;
    int unsigned pick;
    logic [16:0] base_freq;
    logic [14:0] base_amp;
    logic [16:0] f;
    done_ticks = 0;
    while (done_ticks < count) begin
      run_len = $urandom_range(10, 120);
      case ($urandom_range(0, 9))
        0:       base_freq = '0;
        1:       base_freq = 17'($urandom);
        2:       base_freq = FREQ_MAX;
        default: base_freq = 17'($urandom_range(40000, 131071));
      endcase
      case ($urandom_range(0, 7))
        0:       base_amp = '0;
        1:       base_amp = AMP_MAX;
        2:       base_amp = 15'($urandom_range(1, 16));
        default: base_amp = 15'($urandom);
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len && done_ticks < count; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          offer(1'b0, 17'($urandom), 15'($urandom));
        end else begin
          if (pick < 12) begin
            base_freq = 17'(base_freq + $urandom_range(1, 400));
          end else if (pick < 16) begin
            base_amp = 15'($urandom);
          end
          f = (pick >= 96) ? 17'($urandom) : base_freq;
          offer(1'b1, f, base_amp);
          done_ticks++;
        end
      end
    end
    tx_calm = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : stimulus
    for (int k = 0; k <= ROM_TOP; k++) begin
      sine_q15[k] = quarter_sine(k);
    end
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) begin
      offer(plan[i].tick, plan[i].freq, plan[i].amp, plan[i].typed, plan[i].want);
    end
    pause_until_drained();
    random_ticks(HALF_TICKS);
    pause_until_drained();
    random_ticks(HALF_TICKS);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (phase_words_due.size() != 0) begin
      report("words still due", 0, phase_words_due.size());
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Each result word waits its own random stall; once, a long hold lets the pipeline fill.
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    m_axis_tready <= 1'b0;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken % 64 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (taken == HOLD_AFTER) begin
        stall      = LONG_HOLD;
        rx_holding = 1'b1;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rx_holding = 1'b0;
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin : output_compare
    phase_word_t got;
    phase_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = phase_word_t'(m_axis_tdata[65:0]);
      if (phase_words_due.size() == 0) begin
        report("word with nothing due, phase_a", got.phase_a, 0);
      end else begin
        want = phase_words_due.pop_front();
        if (got.phase_a !== want.phase_a) report("phase_a", got.phase_a, want.phase_a);
        if (got.phase_b !== want.phase_b) report("phase_b", got.phase_b, want.phase_b);
        if (got.phase_c !== want.phase_c) report("phase_c", got.phase_c, want.phase_c);
        if (got.crossed !== want.crossed) report("zero_crossed", got.crossed, want.crossed);
        if (got.applied_freq !== want.applied_freq) begin
          report("applied_frequency", got.applied_freq, want.applied_freq);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

### sim.f
hdl/tpsg_pkg.sv
hdl/three_phase_sine_generator.sv
dv/tb_three_phase_sine_generator.sv
